// ----- hw/rtl/multi_token_substring_match_all_assert.svh -----
// Assertion macros for the substring match block.
// Clock and reset names are those of the including module.
`ifndef MULTI_TOKEN_SUBSTRING_MATCH_ALL_ASSERT_SVH
`define MULTI_TOKEN_SUBSTRING_MATCH_ALL_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define MTSM_ASSERT_HOLD(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("mtsm invariant failed");
`define MTSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mtsm sequence check failed");
`else
`define MTSM_ASSERT_HOLD(lbl, expr)
`define MTSM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hw/rtl/mtsm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mtsm_pkg;

    localparam int QUERY_BYTES = 64;
    localparam int MAX_TOKENS  = 8;

    // one cell per kept query position
    localparam int CELLS      = (QUERY_BYTES - 1 > 63) ? 63 : QUERY_BYTES - 1;
    localparam int TOK_IDX_W  = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam int TOK_CNT_W  = $clog2(MAX_TOKENS + 1);
    localparam int TOK_SLOTS  = 1 << TOK_IDX_W;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_TEXT  = 2'd2;
    localparam logic [1:0] CMD_END   = 2'd3;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    typedef logic [TOK_IDX_W-1:0] t_tok_idx;
    typedef logic [TOK_CNT_W-1:0] t_tok_cnt;

    // broadcast from the control section to every cell
    typedef struct packed {
        logic       write;
        logic       text;
        logic       clear;
        logic       drop_match;
        logic       space;
        logic       open_tok;
        logic       start;
        logic [7:0] wr_char;
        logic [7:0] txt_char;
        t_tok_idx   tok_idx;
    } t_cell_ctl;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/multi_token_substring_match_all.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake                  | payload
// input   | in        | i_in_valid / o_in_ready    | i_command, i_char_byte
// result  | out       | o_out_valid / i_out_ready  | o_match_all, o_found_mask,
//         |           |                            | o_token_total_out
//
// One item per cycle while o_in_ready is high: every command completes in the cycle of its transfer;
// the shift-and step runs across the cell row in that same cycle.
// An end-of-text result appears the cycle after its transfer.
// Input stalls only while a result waits and the result side is not ready.
// Synchronous active-low reset empties the query; no clearing pass is needed.

module multi_token_substring_match_all (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_command,
    input  wire logic [7:0] i_char_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_match_all,
    output logic [7:0]      o_found_mask,
    output logic [3:0]      o_token_total_out
);
    import mtsm_pkg::*;

    localparam int FOUND_W = (MAX_TOKENS > 8) ? MAX_TOKENS : 8;
    localparam int TOTAL_W = (TOK_CNT_W > 4) ? TOK_CNT_W : 4;

    logic                  r_inside;
    logic                  r_closed;
    t_tok_cnt              r_total;
    logic [MAX_TOKENS-1:0] r_found;
    logic                  r_out_valid;
    logic                  r_match_all;
    logic [7:0]            r_found_mask;
    logic [3:0]            r_total_out;

    logic                  n_inside;
    logic                  n_closed;
    t_tok_cnt              n_total;
    logic [MAX_TOKENS-1:0] n_found;

    logic                  in_xfer;
    logic                  end_xfer;
    logic [7:0]            folded;
    logic                  is_space;
    logic                  full;
    logic                  keep;
    t_cell_ctl             ctl;

    logic [CELLS-1:0]      v_valid;
    logic [CELLS-1:0]      v_carry;
    logic [CELLS-1:0]      v_hit;
    t_tok_idx              v_idx [CELLS];

    logic [TOK_SLOTS-1:0]  hit_slots;
    logic [MAX_TOKENS-1:0] all_mask;
    logic [MAX_TOKENS-1:0] found_sel;
    logic [FOUND_W-1:0]    found_wide;
    logic [TOTAL_W-1:0]    total_wide;

    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign in_xfer    = i_in_valid & o_in_ready;
    assign end_xfer   = in_xfer & (i_command == CMD_END);

    assign folded   = fold_case(i_char_byte);
    assign is_space = (folded == CHAR_SPACE);
    assign full     = v_valid[CELLS-1];
    assign keep     = in_xfer & (i_command == CMD_QUERY) & ~r_closed
                      & (i_char_byte != 8'd0) & ~full;

    always_comb begin
        ctl            = '0;
        ctl.write      = keep;
        ctl.text       = in_xfer & (i_command == CMD_TEXT);
        ctl.clear      = in_xfer & (i_command == CMD_CLEAR);
        ctl.drop_match = end_xfer;
        ctl.space      = is_space;
        ctl.open_tok   = r_inside;
        ctl.start      = ~is_space & ~r_inside;
        ctl.wr_char    = folded;
        ctl.txt_char   = i_char_byte;
        ctl.tok_idx    = r_inside ? TOK_IDX_W'(r_total - t_tok_cnt'(1))
                                  : TOK_IDX_W'(r_total);
    end

    for (genvar p = 0; p < CELLS; p++) begin : g_cell
        logic prev_valid;
        logic next_valid;
        logic prev_carry;

        if (p == 0) begin : g_head
            assign prev_valid = 1'b1;
            assign prev_carry = 1'b0;
        end else begin : g_body
            assign prev_valid = v_valid[p-1];
            assign prev_carry = v_carry[p-1];
        end

        if (p == CELLS - 1) begin : g_tail
            assign next_valid = 1'b0;
        end else begin : g_inner
            assign next_valid = v_valid[p+1];
        end

        mtsm_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_prev_valid (prev_valid),
            .i_next_valid (next_valid),
            .i_prev_carry (prev_carry),
            .o_valid      (v_valid[p]),
            .o_carry      (v_carry[p]),
            .o_hit        (v_hit[p]),
            .o_tok_idx    (v_idx[p])
        );
    end

    always_comb begin
        hit_slots = '0;
        for (int p = 0; p < CELLS; p++) begin
            if (v_hit[p]) begin
                hit_slots[v_idx[p]] = 1'b1;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_TOKENS; i++) begin
            all_mask[i] = (TOK_CNT_W'(i) < r_total);
        end
    end

    assign found_sel  = r_found & all_mask;
    assign found_wide = FOUND_W'(found_sel);
    assign total_wide = TOTAL_W'(r_total);

    always_comb begin
        n_inside = r_inside;
        n_closed = r_closed;
        n_total  = r_total;
        n_found  = r_found;
        case (ctl.clear ? CMD_CLEAR : i_command)
            CMD_CLEAR: begin
                if (ctl.clear) begin
                    n_inside = 1'b0;
                    n_closed = 1'b0;
                    n_total  = '0;
                    n_found  = '0;
                end
            end
            CMD_QUERY: begin
                if (keep) begin
                    n_inside = ~is_space;
                    if (!is_space && !r_inside) begin
                        n_total = r_total + t_tok_cnt'(1);
                    end
                    if (is_space && r_inside && r_total >= TOK_CNT_W'(MAX_TOKENS)) begin
                        n_closed = 1'b1;
                    end
                end
            end
            CMD_TEXT: begin
                if (ctl.text) begin
                    n_found = r_found | hit_slots[MAX_TOKENS-1:0];
                end
            end
            CMD_END: begin
                if (end_xfer) begin
                    n_found = '0;
                end
            end
            default: begin
                n_found = r_found;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside    <= 1'b0;
            r_closed    <= 1'b0;
            r_total     <= '0;
            r_found     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_inside <= n_inside;
            r_closed <= n_closed;
            r_total  <= n_total;
            r_found  <= n_found;
            if (end_xfer) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (end_xfer) begin
            r_match_all  <= (found_sel == all_mask);
            r_found_mask <= found_wide[7:0];
            r_total_out  <= total_wide[3:0];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_match_all       = r_match_all;
    assign o_found_mask      = r_found_mask;
    assign o_token_total_out = r_total_out;

`include "multi_token_substring_match_all_assert.svh"

    `MTSM_ASSERT_HOLD(a_total_bound, r_total <= TOK_CNT_W'(MAX_TOKENS))
    `MTSM_ASSERT_HOLD(a_found_in_range, (r_found & ~all_mask) == '0)
    `MTSM_ASSERT_HOLD(a_closed_not_inside, !(r_closed && r_inside))
    `MTSM_ASSERT_HOLD(a_cells_packed, (v_valid & (v_valid + CELLS'(1))) == '0)
    `MTSM_ASSERT_NEXT(a_end_result, end_xfer, o_out_valid && r_found == '0)

endmodule

`default_nettype wire

// ----- hw/rtl/mtsm_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mtsm_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire mtsm_pkg::t_cell_ctl  i_ctl,
    input  wire logic                 i_prev_valid,
    input  wire logic                 i_next_valid,
    input  wire logic                 i_prev_carry,
    output logic                      o_valid,
    output logic                      o_carry,
    output logic                      o_hit,
    output mtsm_pkg::t_tok_idx        o_tok_idx
);
    import mtsm_pkg::*;

    logic       r_valid;
    logic       r_start;
    logic       r_end;
    logic       r_match;
    logic [7:0] r_char;
    t_tok_idx   r_tok_idx;

    logic last;
    logic ends;
    logic eq;
    logic n_match;
    logic target;

    // last kept byte; it closes an open token for matching
    assign last    = r_valid & ~i_next_valid;
    assign ends    = r_end | (i_ctl.open_tok & last);
    assign eq      = r_valid & (r_char == i_ctl.txt_char);
    assign n_match = (i_prev_carry | r_start) & eq;
    assign target  = i_prev_valid & ~r_valid;

    assign o_valid   = r_valid;
    assign o_carry   = r_match & ~ends;
    assign o_hit     = i_ctl.text & n_match & ends;
    assign o_tok_idx = r_tok_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_valid <= 1'b0;
            r_start <= 1'b0;
            r_end   <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.write && target) begin
                r_valid <= 1'b1;
                r_start <= i_ctl.start;
            end
            if (i_ctl.write && i_ctl.space && i_ctl.open_tok && last) begin
                r_end <= 1'b1;
            end
            if (i_ctl.text) begin
                r_match <= n_match;
            end else if (i_ctl.drop_match) begin
                r_match <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.write && target) begin
            r_char    <= i_ctl.wr_char;
            r_tok_idx <= i_ctl.tok_idx;
        end
    end

endmodule

`default_nettype wire
